// ----- rtl/rpc_pkg.sv -----
package rpc_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 32;
  localparam int FRAC_BITS        = 16;
  localparam int ANGLE_WIDTH      = 16;
  localparam int ZW               = 32;
  // headroom above coordinate + fraction bits for CORDIC growth
  localparam int GUARD_BITS       = 3;

  localparam logic [29:0]   GAIN_Q30  = 30'd652032874;
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [1:0] REQ_RECT  = 2'd0;
  localparam logic [1:0] REQ_POLAR = 2'd1;

  // atan(2^-i) in 2^32 counts per turn
  localparam logic [ZW-1:0] ATAN_TAB [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef enum logic [1:0] {
    MODE_RECT,
    MODE_POLAR,
    MODE_ERR
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  zero;
  } tag_t;

endpackage

// ----- rtl/rpc_front.sv -----
module rpc_front #(
  parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF,
  parameter int DW          = COORD_WIDTH + rpc_pkg::FRAC_BITS + rpc_pkg::GUARD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          i_vld,
  output logic                          i_rdy,
  input  logic [1:0]                    i_req,
  input  logic signed [COORD_WIDTH-1:0] i_a,
  input  logic signed [COORD_WIDTH-1:0] i_b,
  output logic                          o_vld,
  input  logic                          o_rdy,
  output logic signed [DW-1:0]          o_x,
  output logic signed [DW-1:0]          o_y,
  output logic [rpc_pkg::ZW-1:0]        o_z,
  output rpc_pkg::tag_t                 o_tag,
  output logic signed [COORD_WIDTH-1:0] o_a,
  output logic signed [COORD_WIDTH-1:0] o_b
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = W + 31;
  localparam logic signed [30:0] GAIN_S = $signed({1'b0, rpc_pkg::GAIN_Q30});

  // stage 1: decode and gain multiply
  logic                  v1_r;
  logic                  rdy1;
  logic                  rdy2;
  rpc_pkg::tag_t         tag1_r, tag1_nxt;
  logic signed [W-1:0]   a1_r, b1_r;
  logic signed [PW-1:0]  prod1_r, prod1_nxt;

  // stage 2: initial vector
  logic                  v2_r;
  logic signed [DW-1:0]  x2_r, x2_nxt, y2_r, y2_nxt;
  logic [rpc_pkg::ZW-1:0] z2_r, z2_nxt;
  rpc_pkg::tag_t         tag2_r;
  logic signed [W-1:0]   a2_r, b2_r;

  logic signed [PW:0]    psum;
  logic signed [DW-1:0]  px;
  logic signed [DW-1:0]  ax;
  logic signed [DW-1:0]  by;
  logic [W+15:0]         bz;
  logic [15:0]           ang;

  assign rdy2  = ~v2_r | o_rdy;
  assign rdy1  = ~v1_r | rdy2;
  assign i_rdy = rdy1;

  always_comb begin
    tag1_nxt.zero = (i_a == '0) && (i_b == '0);
    case (i_req)
      rpc_pkg::REQ_RECT:  tag1_nxt.mode = rpc_pkg::MODE_RECT;
      rpc_pkg::REQ_POLAR: tag1_nxt.mode = rpc_pkg::MODE_POLAR;
      default:            tag1_nxt.mode = rpc_pkg::MODE_ERR;
    endcase
    prod1_nxt = PW'(i_a) * PW'(GAIN_S);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      tag1_r  <= tag1_nxt;
      a1_r    <= i_a;
      b1_r    <= i_b;
      prod1_r <= prod1_nxt;
    end
  end

  always_comb begin
    // polar start: floor((m*K + 2^13) / 2^14)
    psum = $signed({prod1_r[PW-1], prod1_r}) + $signed((PW+1)'(8192));
    px   = DW'($signed(psum[PW:14]));
    ax   = $signed({{rpc_pkg::GUARD_BITS{a1_r[W-1]}}, a1_r, 16'b0});
    by   = $signed({{rpc_pkg::GUARD_BITS{b1_r[W-1]}}, b1_r, 16'b0});
    bz   = {16'b0, b1_r};
    ang  = bz[15:0];
    x2_nxt = ax;
    y2_nxt = by;
    z2_nxt = '0;
    if (tag1_r.mode == rpc_pkg::MODE_POLAR) begin
      x2_nxt = px;
      y2_nxt = '0;
      z2_nxt = {ang, 16'b0};
      if (ang[15] ^ ang[14]) begin
        x2_nxt = -px;
        z2_nxt = {ang, 16'b0} ^ rpc_pkg::HALF_TURN;
      end
    end else if (a1_r[W-1]) begin
      // left half plane: rotate by pi first
      x2_nxt = -ax;
      y2_nxt = -by;
      z2_nxt = rpc_pkg::HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      z2_r   <= z2_nxt;
      tag2_r <= tag1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
    end
  end

  assign o_vld = v2_r;
  assign o_x   = x2_r;
  assign o_y   = y2_r;
  assign o_z   = z2_r;
  assign o_tag = tag2_r;
  assign o_a   = a2_r;
  assign o_b   = b2_r;

endmodule

// ----- rtl/rpc_cordic_stage.sv -----
module rpc_cordic_stage #(
  parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF,
  parameter int DW          = COORD_WIDTH + rpc_pkg::FRAC_BITS + rpc_pkg::GUARD_BITS,
  parameter int STEP        = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          i_vld,
  output logic                          i_rdy,
  input  logic signed [DW-1:0]          i_x,
  input  logic signed [DW-1:0]          i_y,
  input  logic [rpc_pkg::ZW-1:0]        i_z,
  input  rpc_pkg::tag_t                 i_tag,
  input  logic signed [COORD_WIDTH-1:0] i_a,
  input  logic signed [COORD_WIDTH-1:0] i_b,
  output logic                          o_vld,
  input  logic                          o_rdy,
  output logic signed [DW-1:0]          o_x,
  output logic signed [DW-1:0]          o_y,
  output logic [rpc_pkg::ZW-1:0]        o_z,
  output rpc_pkg::tag_t                 o_tag,
  output logic signed [COORD_WIDTH-1:0] o_a,
  output logic signed [COORD_WIDTH-1:0] o_b
);

  localparam logic [rpc_pkg::ZW-1:0] ATAN = rpc_pkg::ATAN_TAB[STEP];

  logic                          v_r;
  logic                          rdy;
  logic                          plus;
  logic signed [DW-1:0]          dx, dy;
  logic signed [DW-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic [rpc_pkg::ZW-1:0]        z_r, z_nxt;
  rpc_pkg::tag_t                 tag_r;
  logic signed [COORD_WIDTH-1:0] a_r, b_r;

  assign rdy   = ~v_r | o_rdy;
  assign i_rdy = rdy;

  always_comb begin
    dx = i_y >>> STEP;
    dy = i_x >>> STEP;
    // vectoring drives y to zero; rotation drives z to zero
    if (i_tag.mode == rpc_pkg::MODE_RECT) begin
      plus = ~i_y[DW-1];
    end else begin
      plus = i_z[rpc_pkg::ZW-1];
    end
    if (plus) begin
      x_nxt = i_x + dx;
      y_nxt = i_y - dy;
      z_nxt = i_z + ATAN;
    end else begin
      x_nxt = i_x - dx;
      y_nxt = i_y + dy;
      z_nxt = i_z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= i_tag;
      a_r   <= i_a;
      b_r   <= i_b;
    end
  end

  assign o_vld = v_r;
  assign o_x   = x_r;
  assign o_y   = y_r;
  assign o_z   = z_r;
  assign o_tag = tag_r;
  assign o_a   = a_r;
  assign o_b   = b_r;

endmodule

// ----- rtl/rpc_back.sv -----
module rpc_back #(
  parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF,
  parameter int DW          = COORD_WIDTH + rpc_pkg::FRAC_BITS + rpc_pkg::GUARD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          i_vld,
  output logic                          i_rdy,
  input  logic signed [DW-1:0]          i_x,
  input  logic signed [DW-1:0]          i_y,
  input  logic [rpc_pkg::ZW-1:0]        i_z,
  input  rpc_pkg::tag_t                 i_tag,
  input  logic signed [COORD_WIDTH-1:0] i_a,
  input  logic signed [COORD_WIDTH-1:0] i_b,
  output logic                          o_vld,
  input  logic                          o_rdy,
  output logic signed [COORD_WIDTH-1:0] o_x,
  output logic signed [COORD_WIDTH-1:0] o_y,
  output logic signed [COORD_WIDTH:0]   o_mag,
  output logic signed [15:0]            o_ang,
  output logic                          o_err
);

  localparam int W   = COORD_WIDTH;
  localparam int HW  = DW - 17;      // u >> 16
  localparam int PHW = W + 32;
  localparam int RW  = DW - 15;      // rounded coordinate
  localparam int TW  = PHW + 1;

  // stage 1: gain products and rounding
  logic                  v1_r;
  logic                  rdy1;
  logic                  rdy2;
  logic [DW-2:0]         u;
  logic [HW-1:0]         hi;
  logic [45:0]           plo;
  logic [PHW-1:0]        phi_r, phi_nxt;
  logic [29:0]           plo_r;
  logic signed [DW:0]    xa, ya;
  logic signed [RW-1:0]  xr_r, yr_r;
  logic [15:0]           angr_r, angr_nxt;
  rpc_pkg::tag_t         tag1_r;
  logic signed [W-1:0]   a1_r, b1_r;

  // stage 2: cap, saturate, select
  logic                  v2_r;
  logic [TW-1:0]         t;
  logic [TW-31:0]        t2;
  logic [W-1:0]          magu;
  logic [W+15:0]         bz;
  logic signed [W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [W:0]     mag_r, mag_nxt;
  logic [15:0]           ang_r, ang_nxt;
  logic                  err_r, err_nxt;

  function automatic logic signed [W-1:0] sat_c(input logic signed [RW-1:0] v);
    logic [RW-W:0] top;
    top = v[RW-1:W-1];
    if ((top == '0) || (top == '1)) begin
      sat_c = v[W-1:0];
    end else if (v[RW-1]) begin
      sat_c = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  assign rdy2  = ~v2_r | o_rdy;
  assign rdy1  = ~v1_r | rdy2;
  assign i_rdy = rdy1;

  always_comb begin
    u        = i_x[DW-1] ? '0 : i_x[DW-2:0];
    hi       = u[DW-2:16];
    phi_nxt  = PHW'(hi) * PHW'(rpc_pkg::GAIN_Q30);
    plo      = 46'(u[15:0]) * 46'(rpc_pkg::GAIN_Q30);
    xa       = $signed({i_x[DW-1], i_x}) + $signed((DW+1)'(32768));
    ya       = $signed({i_y[DW-1], i_y}) + $signed((DW+1)'(32768));
    angr_nxt = i_z[31:16] + {15'b0, i_z[15]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      phi_r  <= phi_nxt;
      plo_r  <= plo[45:16];
      xr_r   <= xa[DW:16];
      yr_r   <= ya[DW:16];
      angr_r <= angr_nxt;
      tag1_r <= i_tag;
      a1_r   <= i_a;
      b1_r   <= i_b;
    end
  end

  always_comb begin
    // round half up out of Q30, then cap at 2^W - 1
    t    = TW'(phi_r) + TW'(plo_r) + TW'(32'h2000_0000);
    t2   = t[TW-1:30];
    magu = (t2[TW-31:W] != '0) ? '1 : t2[W-1:0];
    bz   = {16'b0, b1_r};
    x_nxt   = '0;
    y_nxt   = '0;
    mag_nxt = '0;
    ang_nxt = '0;
    err_nxt = 1'b0;
    case (tag1_r.mode)
      rpc_pkg::MODE_RECT: begin
        x_nxt = a1_r;
        y_nxt = b1_r;
        if (!tag1_r.zero) begin
          mag_nxt = $signed({1'b0, magu});
          ang_nxt = angr_r;
        end
      end
      rpc_pkg::MODE_POLAR: begin
        x_nxt   = sat_c(xr_r);
        y_nxt   = sat_c(yr_r);
        mag_nxt = $signed({a1_r[W-1], a1_r});
        ang_nxt = bz[15:0];
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      mag_r <= mag_nxt;
      ang_r <= ang_nxt;
      err_r <= err_nxt;
    end
  end

  assign o_vld = v2_r;
  assign o_x   = x_r;
  assign o_y   = y_r;
  assign o_mag = mag_r;
  assign o_ang = $signed(ang_r);
  assign o_err = err_r;

endmodule

// ----- rtl/rect_polar_converter_unit.sv -----
// channel | dir | tdata (low bit up)                        | tuser
// in_     | in  | first_operand, second_operand             | req_type
// out_    | out | x_coord, y_coord, magnitude, angle         | form_error
//
// One beat in and one beat out per cycle while out_tready is high, no stored
// state between items. Two front stages (gain multiply, initial vector), one
// register per CORDIC iteration, two back stages (gain multiply, round/saturate
// into the output register).
// Reset clears the stage valid bits only. A stall at out_ holds stages that are
// full and lets bubbles fill, so in_tready stays high while any bubble remains.
module rect_polar_converter_unit #(
  parameter int COORD_WIDTH  = rpc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF,
  localparam int IN_TW  = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((3 * COORD_WIDTH + 17 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // first_operand, second_operand
  input  logic [1:0]        in_tuser,   // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // x_coord, y_coord, magnitude, angle
  output logic              out_tuser   // form_error
);

  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + rpc_pkg::FRAC_BITS + rpc_pkg::GUARD_BITS;
  localparam int STEPS = (CORDIC_STEPS > rpc_pkg::MAX_STEPS) ? rpc_pkg::MAX_STEPS
                                                             : CORDIC_STEPS;

  logic                   cv  [STEPS+1];
  logic                   cr  [STEPS+1];
  logic signed [DW-1:0]   cx  [STEPS+1];
  logic signed [DW-1:0]   cy  [STEPS+1];
  logic [rpc_pkg::ZW-1:0] cz  [STEPS+1];
  rpc_pkg::tag_t          ct  [STEPS+1];
  logic signed [W-1:0]    ca  [STEPS+1];
  logic signed [W-1:0]    cb  [STEPS+1];

  logic signed [W-1:0]    res_x, res_y;
  logic signed [W:0]      res_mag;
  logic signed [15:0]     res_ang;

  rpc_front #(
    .COORD_WIDTH (W),
    .DW          (DW)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .i_vld (in_tvalid),
    .i_rdy (in_tready),
    .i_req (in_tuser),
    .i_a   ($signed(in_tdata[W-1:0])),
    .i_b   ($signed(in_tdata[2*W-1:W])),
    .o_vld (cv[0]),
    .o_rdy (cr[0]),
    .o_x   (cx[0]),
    .o_y   (cy[0]),
    .o_z   (cz[0]),
    .o_tag (ct[0]),
    .o_a   (ca[0]),
    .o_b   (cb[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    rpc_cordic_stage #(
      .COORD_WIDTH (W),
      .DW          (DW),
      .STEP        (k)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .i_vld (cv[k]),
      .i_rdy (cr[k]),
      .i_x   (cx[k]),
      .i_y   (cy[k]),
      .i_z   (cz[k]),
      .i_tag (ct[k]),
      .i_a   (ca[k]),
      .i_b   (cb[k]),
      .o_vld (cv[k+1]),
      .o_rdy (cr[k+1]),
      .o_x   (cx[k+1]),
      .o_y   (cy[k+1]),
      .o_z   (cz[k+1]),
      .o_tag (ct[k+1]),
      .o_a   (ca[k+1]),
      .o_b   (cb[k+1])
    );
  end

  rpc_back #(
    .COORD_WIDTH (W),
    .DW          (DW)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .i_vld (cv[STEPS]),
    .i_rdy (cr[STEPS]),
    .i_x   (cx[STEPS]),
    .i_y   (cy[STEPS]),
    .i_z   (cz[STEPS]),
    .i_tag (ct[STEPS]),
    .i_a   (ca[STEPS]),
    .i_b   (cb[STEPS]),
    .o_vld (out_tvalid),
    .o_rdy (out_tready),
    .o_x   (res_x),
    .o_y   (res_y),
    .o_mag (res_mag),
    .o_ang (res_ang),
    .o_err (out_tuser)
  );

  assign out_tdata = OUT_TW'({res_ang, res_mag, res_y, res_x});

endmodule
